@@ src/ale_pkg.sv @@
`timescale 1ns / 1ps

package ale_pkg;

    localparam int CH_W      = 8;
    localparam int WORD_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int OPCODE_W  = 4;
    localparam int OPERAND_W = 12;
    localparam int MN_CHARS  = 4;
    localparam int MN_W      = MN_CHARS * CH_W;
    localparam int MN_LEN_W  = 3;
    localparam int MN_COUNT  = 15;

    localparam logic [OPERAND_W-1:0] OPERAND_MAX = 12'd4095;
    localparam logic [MN_LEN_W-1:0]  MN_LEN_FULL = 3'd4;
    localparam logic [MN_LEN_W-1:0]  MN_LEN_LONG = 3'd5;

    localparam logic [CH_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CH_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_MNEMON  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_OPERAND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 2'd3;

    // first character in the top byte
    localparam logic [MN_W-1:0] MN_TABLE [MN_COUNT] = '{
        "lodd", "stod", "addd", "subd", "jpos", "jzer", "jump", "loco",
        "lodl", "stol", "addl", "subl", "jneg", "jnze", "call"
    };

    typedef struct packed {
        logic                found;
        logic [OPCODE_W-1:0] opcode;
    } t_match;

    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [STATUS_W-1:0] status;
    } t_result;

    function automatic t_match match_mnemonic(input logic [MN_W-1:0] chars);
        t_match m;
        m.found  = 1'b0;
        m.opcode = '0;
        for (int k = 0; k < MN_COUNT; k++) begin
            if (chars == MN_TABLE[k]) begin
                m.found  = 1'b1;
                m.opcode = OPCODE_W'(k);
            end
        end
        return m;
    endfunction

endpackage

@@ src/ale_parse.sv @@
`timescale 1ns / 1ps

module ale_parse import ale_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_beat,
    input  logic [CH_W-1:0] i_ch,
    output logic            o_emit,
    output t_result         o_result
);

    logic [MN_W-1:0]      r_mn, n_mn;
    logic [MN_LEN_W-1:0]  r_len, n_len;
    logic                 r_in_operand, n_in_operand;
    logic [OPCODE_W-1:0]  r_opcode, n_opcode;
    logic [OPERAND_W-1:0] r_val, n_val;
    logic [STATUS_W-1:0]  r_err, n_err;
    logic                 r_pend_nd, n_pend_nd;
    logic                 r_pend_over, n_pend_over;

    logic        w_sep;
    logic        w_digit;
    t_match      w_match;
    logic [15:0] w_next_val;

    assign w_sep      = (i_ch == CH_SPACE) || (i_ch == CH_NEWLINE) || (i_ch == CH_NUL);
    assign w_match    = match_mnemonic(r_mn);
    assign w_next_val = {1'b0, r_val, 3'b000} + {3'b000, r_val, 1'b0}
                      + {12'd0, i_ch[3:0]};

    always_comb begin
        w_digit      = i_ch inside {[CH_ZERO:CH_NINE]};
        n_mn         = r_mn;
        n_len        = r_len;
        n_in_operand = r_in_operand;
        n_opcode     = r_opcode;
        n_val        = r_val;
        n_err        = r_err;
        n_pend_nd    = r_pend_nd;
        n_pend_over  = r_pend_over;
        if (w_sep) begin
            if (!r_in_operand) begin
                n_in_operand = 1'b1;
                if ((r_len == MN_LEN_FULL) && w_match.found) begin
                    n_opcode = w_match.opcode;
                end else begin
                    n_opcode = '0;
                    if (n_err == ST_OK) n_err = ST_BAD_MNEMON;
                end
            end
            if (n_err == ST_OK) begin
                if (r_pend_nd) begin
                    n_err = ST_BAD_OPERAND;
                end else if (r_pend_over) begin
                    n_err = ST_OVERFLOW;
                end
            end
        end else if (!r_in_operand) begin
            if (r_len < MN_LEN_FULL) begin
                n_mn  = {r_mn[MN_W-CH_W-1:0], i_ch};
                n_len = r_len + 1'b1;
            end else begin
                n_len = MN_LEN_LONG;
            end
        end else if (w_digit) begin
            if (w_next_val > {4'd0, OPERAND_MAX}) begin
                n_val       = OPERAND_MAX;
                n_pend_over = 1'b1;
            end else begin
                n_val = w_next_val[OPERAND_W-1:0];
            end
        end else begin
            n_pend_nd = 1'b1;
        end
    end

    assign o_emit          = (i_ch == CH_NUL);
    assign o_result.word   = {n_opcode, n_val};
    assign o_result.status = n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_beat && o_emit)) begin
            r_mn         <= '0;
            r_len        <= '0;
            r_in_operand <= 1'b0;
            r_opcode     <= '0;
            r_val        <= '0;
            r_err        <= ST_OK;
            r_pend_nd    <= 1'b0;
            r_pend_over  <= 1'b0;
        end else if (i_beat) begin
            r_mn         <= n_mn;
            r_len        <= n_len;
            r_in_operand <= n_in_operand;
            r_opcode     <= n_opcode;
            r_val        <= n_val;
            r_err        <= n_err;
            r_pend_nd    <= n_pend_nd;
            r_pend_over  <= n_pend_over;
        end
    end

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= MN_LEN_LONG)
        else $error("mnemonic length out of range");

    a_no_operand_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_operand |-> (!r_pend_nd && !r_pend_over && (r_val == '0)))
        else $error("operand state set while reading mnemonic");

    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beat && o_emit) |=> (!r_in_operand && (r_len == '0) && (r_err == ST_OK)))
        else $error("line state not cleared after end of line");

endmodule

@@ src/assembly_line_encoder_core.sv @@
`timescale 1ns / 1ps
// assembly line encoder
// input channel: one ascii character per beat on i_ch (i_valid / o_ready).
// space and newline separate tokens, nul ends the line.
// output channel: one beat per line on o_word / o_status (o_valid / i_ready),
// raised for the nul beat only; other characters give no output beat.
// o_word carries the opcode in bits 15..12 and the operand in 11..0,
// o_status the first error (0 ok, 1 unknown mnemonic, 2 bad operand,
// 3 operand over 4095).
// throughput: one character per cycle, unless a nul waits in the input
// register while the output register holds its beat; the character step
// between the input register and the output register is combinational.
// a nul is held in the input register and its result in the output register.
// reset: all line state cleared, both registers empty, next character
// starts a new mnemonic.
// receiver stall: the output register holds its beat; characters that give
// no output keep flowing, a following nul waits in the input register and
// o_ready drops until the output register frees.
module assembly_line_encoder_core import ale_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CH_W-1:0]     i_ch,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [WORD_W-1:0]   o_word,
    output logic [STATUS_W-1:0] o_status
);

    logic            r_in_valid;
    logic [CH_W-1:0] r_ch;
    logic            r_out_valid;
    t_result         r_out;

    logic    w_emit;
    logic    w_advance;
    t_result w_result;

    ale_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (w_advance),
        .i_ch     (r_ch),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    assign w_advance = r_in_valid && (!w_emit || !r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign o_valid   = r_out_valid;
    assign o_word    = r_out.word;
    assign o_status  = r_out.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_advance && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_valid && o_ready) begin
            r_ch <= i_ch;
        end
        if (w_advance && w_emit) begin
            r_out <= w_result;
        end
    end

    a_stall_blocks_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_emit && r_out_valid && !i_ready) |-> !w_advance)
        else $error("end of line taken while output beat is held");

    a_held_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_ch)))
        else $error("pending character lost");

    a_out_from_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_advance && w_emit))
        else $error("output beat without end of line");

endmodule

@@ tb/assembly_line_encoder_core_test.sv @@
`timescale 1ns / 1ps

module assembly_line_encoder_core_test;
    import ale_pkg::*;

    localparam int LONG_HOLD = 400;

    localparam logic [MN_W-1:0] MNEMONICS [MN_COUNT] = '{
        "lodd", "stod", "addd", "subd", "jpos", "jzer", "jump", "loco",
        "lodl", "stol", "addl", "subl", "jneg", "jnze", "call"
    };

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic [3:0]      gap;
        logic            hold;
    } t_char_beat;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [CH_W-1:0]     i_ch = CH_NUL;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [WORD_W-1:0]   o_word;
    logic [STATUS_W-1:0] o_status;

    assembly_line_encoder_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_ch     (i_ch),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_word   (o_word),
        .o_status (o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // line state of the predictor
    logic [MN_W-1:0]      mn_buf = '0;
    logic [MN_LEN_W-1:0]  mn_len = '0;
    bit                   past_mnemonic = 1'b0;
    logic [OPCODE_W-1:0]  opc = '0;
    logic [OPERAND_W-1:0] operand = '0;
    logic [STATUS_W-1:0]  first_err = ST_OK;
    bit                   saw_junk = 1'b0;
    bit                   saw_big = 1'b0;

    t_result    pending_words [$];
    t_char_beat char_q [$];

    int n_errors = 0;
    int n_chars = 0;
    int n_words = 0;
    int n_flagged = 0;
    int n_in_stall = 0;
    int n_out_stall = 0;
    int n_pushed = 0;
    bit tx_calm = 1'b0;
    bit hold_next = 1'b0;

    logic [3:0] tx_wait = '0;
    int         rx_wait = 0;
    int         rx_beats = 0;
    bit         rx_calm = 1'b0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic void note_error(input logic [STATUS_W-1:0] code);
        if (first_err == ST_OK)
            first_err = code;
    endfunction

    task automatic assemble_char(input logic [CH_W-1:0] c);
        int unsigned v;
        t_result     r;
        bit          found;
        if (c == CH_SPACE || c == CH_NEWLINE || c == CH_NUL) begin
            if (!past_mnemonic) begin
                found = 1'b0;
                opc = '0;
                if (mn_len == MN_LEN_FULL) begin
                    for (int k = 0; k < MN_COUNT; k++) begin
                        if (mn_buf == MNEMONICS[k]) begin
                            opc = OPCODE_W'(k);
                            found = 1'b1;
                        end
                    end
                end
                if (!found)
                    note_error(ST_BAD_MNEMON);
                past_mnemonic = 1'b1;
            end
            if (saw_junk)
                note_error(ST_BAD_OPERAND);
            else if (saw_big)
                note_error(ST_OVERFLOW);
            if (c == CH_NUL) begin
                r.word = {opc, operand};
                r.status = first_err;
                pending_words.push_back(r);
                mn_buf = '0;
                mn_len = '0;
                past_mnemonic = 1'b0;
                opc = '0;
                operand = '0;
                first_err = ST_OK;
                saw_junk = 1'b0;
                saw_big = 1'b0;
            end
        end else if (!past_mnemonic) begin
            if (mn_len < MN_LEN_FULL) begin
                mn_buf = {mn_buf[MN_W-CH_W-1:0], c};
                mn_len = mn_len + 1'b1;
            end else begin
                mn_len = MN_LEN_LONG;
            end
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            v = operand * 10 + (c - CH_ZERO);
            if (v > OPERAND_MAX) begin
                v = OPERAND_MAX;
                saw_big = 1'b1;
            end
            operand = v[OPERAND_W-1:0];
        end else begin
            saw_junk = 1'b1;
        end
    endtask

    task automatic push_ch(input logic [CH_W-1:0] c);
        t_char_beat b;
        if (n_pushed % 90 == 0)
            tx_calm = ($urandom_range(0, 2) == 0);
        b.ch = c;
        b.gap = tx_calm ? 4'd0 : 4'($urandom_range(0, 12));
        b.hold = hold_next;
        hold_next = 1'b0;
        char_q.push_back(b);
        n_pushed++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_ch(s[i]);
    endtask

    task automatic push_line(input string s);
        push_str(s);
        push_ch(CH_NUL);
    endtask

    function automatic logic [CH_W-1:0] rand_glyph();
        logic [CH_W-1:0] c;
        do
            c = CH_W'($urandom_range(1, 255));
        while (c == CH_SPACE || c == CH_NEWLINE);
        return c;
    endfunction

    task automatic push_gap_chars();
        repeat ($urandom_range(1, 3))
            push_ch($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE);
    endtask

    task automatic build_line();
        int kind;
        int k;
        int n;
        int val;
        logic [MN_W-1:0] mn;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            repeat ($urandom_range(0, 12))
                push_ch(CH_W'($urandom_range(1, 255)));
            push_ch(CH_NUL);
        end else begin
            k = $urandom_range(0, MN_COUNT - 1);
            mn = MNEMONICS[k];
            if (kind < 80) begin
                for (int i = 0; i < MN_CHARS; i++)
                    push_ch(mn[MN_W-1-CH_W*i -: CH_W]);
            end else if (kind < 86) begin
                mn[CH_W*$urandom_range(0, MN_CHARS - 1) +: CH_W] = rand_glyph();
                for (int i = 0; i < MN_CHARS; i++)
                    push_ch(mn[MN_W-1-CH_W*i -: CH_W]);
            end else if (kind < 93) begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    push_ch(mn[MN_W-1-CH_W*i -: CH_W]);
            end else begin
                for (int i = 0; i < MN_CHARS; i++)
                    push_ch(mn[MN_W-1-CH_W*i -: CH_W]);
                repeat ($urandom_range(1, 2))
                    push_ch(rand_glyph());
            end
            n = $urandom_range(0, 3);
            for (int t = 0; t < n; t++) begin
                push_gap_chars();
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: val = $urandom_range(0, 4095);
                    5, 6:          val = $urandom_range(4090, 4100);
                    7, 8:          val = $urandom_range(0, 99999);
                    default:       val = $urandom_range(0, 9);
                endcase
                if ($urandom_range(0, 7) == 0)
                    push_str("00");
                push_str($sformatf("%0d", val));
                if ($urandom_range(0, 15) == 0)
                    push_ch(rand_glyph());
            end
            if ($urandom_range(0, 3) == 0)
                push_gap_chars();
            push_ch(CH_NUL);
        end
    endtask

    // character driver
    always @(posedge i_clk) begin : drive
        t_char_beat nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ch <= CH_NUL;
            tx_wait <= '0;
        end else begin
            if (i_valid && o_ready) begin
                assemble_char(i_ch);
                n_chars++;
            end
            if (i_valid && !o_ready)
                n_in_stall++;
            if (!i_valid || o_ready) begin
                if (tx_wait != 0) begin
                    tx_wait <= tx_wait - 1'b1;
                    i_valid <= 1'b0;
                end else if (char_q.size() != 0 &&
                             !(char_q[0].hold && pending_words.size() != 0)) begin
                    nxt = char_q.pop_front();
                    i_valid <= 1'b1;
                    i_ch <= nxt.ch;
                    tx_wait <= nxt.gap;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver
    always @(posedge i_clk) begin : accept
        int w;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait <= 0;
            rx_beats <= 0;
        end else if (o_valid && i_ready) begin
            rx_beats <= rx_beats + 1;
            if (rx_beats == 40 || rx_beats == 150)
                w = LONG_HOLD;
            else if (rx_calm)
                w = 0;
            else
                w = $urandom_range(0, 12);
            if (rx_beats % 32 == 31)
                rx_calm <= ($urandom_range(0, 2) == 0);
            rx_wait <= w;
            i_ready <= (w == 0);
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            i_ready <= (rx_wait == 1);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watch
        t_result want;
        if (i_rst_n && o_valid && !i_ready)
            n_out_stall++;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_words.size() == 0) begin
                report("unexpected word", 32'(o_word), {30'd0, o_status});
            end else begin
                want = pending_words.pop_front();
                if (o_word !== want.word)
                    report("word", 32'(o_word), 32'(want.word));
                if (o_status !== want.status)
                    report("status", 32'(o_status), 32'(want.status));
                n_words++;
                if (want.status != ST_OK)
                    n_flagged++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : run
        int lines;
        push_line("lodd 0");
        push_line("stod 4095");
        push_line("addd 4096");
        push_line("subd 12a");
        push_line("jpos");
        push_line("jzer 1 2\n3");
        push_line("jump\n7");
        push_line("loco 99999");
        push_line("lodl x 99999");
        push_line("stol 99999x");
        push_line("addl 5000 x");
        push_line("subl 00004095");
        push_line("jneg 1 ");
        push_line("jnze 65535");
        push_line("call 4095\n");
        push_line("lodds 1");
        push_line(" lodd 5");
        push_line("");
        push_line("\n \n");
        push_line("LODD 1");
        push_line("lod 1");
        push_line("bad 5000");
        repeat (MN_CHARS)
            push_ch(8'hff);
        push_ch(CH_SPACE);
        push_ch(8'h80);
        push_ch(8'h7f);
        push_ch(CH_NUL);

        hold_next = 1'b1;
        lines = 0;
        while (n_pushed < 1850) begin
            if (lines % 30 == 29)
                hold_next = 1'b1;
            build_line();
            lines++;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_q.size() != 0 || i_valid || pending_words.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run covered %0d characters, %0d words, %0d of them with an error status",
                 n_chars, n_words, n_flagged);
        $display("input stalled %0d cycles, output held %0d cycles", n_in_stall, n_out_stall);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
src/ale_pkg.sv
src/ale_parse.sv
src/assembly_line_encoder_core.sv
tb/assembly_line_encoder_core_test.sv
